// ----- design/rdq_pkg.sv -----
// rdq_pkg: shared types, constants and lookup tables for the RGB565 downscale quantizer.
// Used by rdq_sampler, rdq_channel and rgb565_downscale_quantizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;

  localparam int COL_W  = $clog2(SRC_WIDTH);
  localparam int ROW_W  = $clog2(SRC_HEIGHT);
  localparam int OW_W   = 9;
  localparam int OH_W   = 8;
  localparam int OFF_W  = 18;
  localparam int CACC_W = $clog2(SRC_WIDTH * SRC_WIDTH + 1);
  localparam int RACC_W = $clog2(SRC_HEIGHT * SRC_HEIGHT + 1);
  localparam int CCMP_W = (CACC_W > COL_W + 1 + OW_W) ? CACC_W : COL_W + 1 + OW_W;
  localparam int RCMP_W = (RACC_W > ROW_W + 1 + OH_W) ? RACC_W : ROW_W + 1 + OH_W;

  // Quantizer: q = floor((mag * inv + 255 * 2^15) / (255 * 2^16))
  localparam int PROD_W = 40;
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(255 * 32768);
  localparam logic [23:0]       SAT_LIMIT  = 24'd65280;
  localparam logic [16:0]       RECIP_255  = 17'd65794;

  typedef enum logic [2:0] {
    CFG_SIGNED_RANGE  = 3'd0,
    CFG_QUANTIZED     = 3'd1,
    CFG_INVERSE_SCALE = 3'd2,
    CFG_ZERO_POINT    = 3'd3,
    CFG_OUT_WIDTH     = 3'd4,
    CFG_OUT_HEIGHT    = 3'd5,
    CFG_CHANNELS      = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic [OFF_W-1:0]   element_offset;
    logic signed [15:0] red_value;
    logic signed [15:0] green_value;
    logic signed [15:0] blue_value;
    logic               frame_done;
  } out_word_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  typedef logic [31:0][7:0]   exp5_lut_t;
  typedef logic [63:0][7:0]   exp6_lut_t;
  typedef logic [255:0][14:0] q14_lut_t;

  function automatic exp5_lut_t build_exp5();
    exp5_lut_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 8'((i * 255) / 31);
    end
    return lut;
  endfunction

  function automatic exp6_lut_t build_exp6();
    exp6_lut_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 8'((i * 255) / 63);
    end
    return lut;
  endfunction

  // round half away of m * 16384 / 255 for magnitudes
  function automatic q14_lut_t build_q14();
    q14_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 15'((2 * i * 16384 + 255) / 510);
    end
    return lut;
  endfunction

  localparam exp5_lut_t EXP5_LUT = build_exp5();
  localparam exp6_lut_t EXP6_LUT = build_exp6();
  localparam q14_lut_t  Q14_LUT  = build_q14();

endpackage

`default_nettype wire

// ----- design/rgb565_downscale_quantizer.sv -----
// rgb565_downscale_quantizer: top level, config registers, pipeline control, offset path.
// Depends on rdq_pkg, rdq_sampler and rdq_channel.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one RGB565 pixel per word
//   in raster order; frame_start marks the first pixel of a frame.
//   Output channel (out_valid_o / out_stall_i / out_word_o) carries one tensor element
//   word for each kept pixel; dropped pixels produce nothing.
//   Config channel (cfg_valid_i / cfg_ready_o) writes a register by index; always ready.
//   Write config only while no pixel is in flight.
// Throughput: one pixel per cycle, sustained, in the absence of output stall.
// Path: a kept pixel passes from the input register through the sampler stage and
//   three value stages into the output register.
// Stall: the pipeline closes bubbles; when the output stalls and all stages are full,
//   in_stall_o rises in the same cycle.
// Reset: position state cleared, registers to their defaults, all stages empty.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_downscale_quantizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rdq_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rdq_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  // config
  logic                      signed_range_q;
  logic                      quantized_q;
  logic [31:0]               inverse_scale_q;
  logic signed [7:0]         zero_point_q;
  logic [rdq_pkg::OW_W-1:0]  out_width_q;
  logic [rdq_pkg::OH_W-1:0]  out_height_q;
  logic [1:0]                channels_q;

  logic [rdq_pkg::OW_W-1:0]  eow;
  logic [rdq_pkg::OH_W-1:0]  eoh;
  logic [1:0]                ch_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_range_q  <= 1'b0;
      quantized_q     <= 1'b1;
      inverse_scale_q <= 32'h00FF_0000;
      zero_point_q    <= '0;
      out_width_q     <= 9'd128;
      out_height_q    <= 8'd128;
      channels_q      <= 2'd3;
    end else if (cfg_valid_i) begin
      unique case (rdq_pkg::cfg_index_e'(cfg_index_i))
        rdq_pkg::CFG_SIGNED_RANGE:  signed_range_q  <= cfg_data_i[0];
        rdq_pkg::CFG_QUANTIZED:     quantized_q     <= cfg_data_i[0];
        rdq_pkg::CFG_INVERSE_SCALE: inverse_scale_q <= cfg_data_i;
        rdq_pkg::CFG_ZERO_POINT:    zero_point_q    <= cfg_data_i[7:0];
        rdq_pkg::CFG_OUT_WIDTH:     out_width_q     <= cfg_data_i[rdq_pkg::OW_W-1:0];
        rdq_pkg::CFG_OUT_HEIGHT:    out_height_q    <= cfg_data_i[rdq_pkg::OH_W-1:0];
        rdq_pkg::CFG_CHANNELS:      channels_q      <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (out_width_q == '0) begin
      eow = rdq_pkg::OW_W'(1);
    end else if (int'(out_width_q) > rdq_pkg::SRC_WIDTH) begin
      eow = rdq_pkg::OW_W'(rdq_pkg::SRC_WIDTH);
    end else begin
      eow = out_width_q;
    end
    if (out_height_q == '0) begin
      eoh = rdq_pkg::OH_W'(1);
    end else if (int'(out_height_q) > rdq_pkg::SRC_HEIGHT) begin
      eoh = rdq_pkg::OH_W'(rdq_pkg::SRC_HEIGHT);
    end else begin
      eoh = out_height_q;
    end
    ch_eff = (channels_q == 2'd0) ? 2'd1 : channels_q;
  end

  // pipeline control
  logic v0_q, v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdyo;
  rdq_pkg::pipe_en_t ch_en;

  always_comb begin
    rdyo = !vo_q || !out_stall_i;
    rdy4 = !v4_q || rdyo;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    rdy0 = !v0_q || rdy1;
    ch_en.s2 = rdy2;
    ch_en.s3 = rdy3;
    ch_en.s4 = rdy4;
  end

  assign in_stall_o  = !rdy0;
  assign out_valid_o = vo_q;

  // stage 0: input register
  rdq_pkg::in_word_t s0_q;
  logic              adv;
  logic              keep;
  logic [rdq_pkg::OFF_W-1:0] base;
  logic              fd;

  assign adv = v0_q && rdy1;

  rdq_sampler u_sampler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .frame_start_i (s0_q.frame_start),
    .out_width_i   (eow),
    .out_height_i  (eoh),
    .keep_o        (keep),
    .base_o        (base),
    .frame_done_o  (fd)
  );

  // channel expansion and magnitude
  logic [2:0][7:0] v8;
  logic [2:0][8:0] twice;
  logic [2:0][7:0] mag;
  logic [2:0]      neg;

  always_comb begin
    v8[0] = rdq_pkg::EXP5_LUT[s0_q.pixel[15:11]];
    v8[1] = rdq_pkg::EXP6_LUT[s0_q.pixel[10:5]];
    v8[2] = rdq_pkg::EXP5_LUT[s0_q.pixel[4:0]];
    for (int k = 0; k < 3; k++) begin
      twice[k] = {v8[k], 1'b0};
      if (!signed_range_q) begin
        mag[k] = v8[k];
        neg[k] = 1'b0;
      end else if (v8[k][7]) begin
        mag[k] = 8'(twice[k] - 9'd255);
        neg[k] = 1'b0;
      end else begin
        mag[k] = 8'(9'd255 - twice[k]);
        neg[k] = 1'b1;
      end
    end
  end

  // stage payloads
  logic [2:0][7:0]           mag1_q;
  logic [2:0]                neg1_q;
  logic [rdq_pkg::OFF_W-1:0] base1_q, off2_q, off3_q, off4_q;
  logic                      fd1_q, fd2_q, fd3_q, fd4_q;
  rdq_pkg::out_word_t        out_q;
  logic [2:0][15:0]          chan_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q && keep;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdyo) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      s0_q <= in_word_i;
    end
    if (rdy1) begin
      mag1_q  <= mag;
      neg1_q  <= neg;
      base1_q <= base;
      fd1_q   <= fd;
    end
    if (rdy2) begin
      off2_q <= rdq_pkg::OFF_W'(base1_q * rdq_pkg::OFF_W'(ch_eff));
      fd2_q  <= fd1_q;
    end
    if (rdy3) begin
      off3_q <= off2_q;
      fd3_q  <= fd2_q;
    end
    if (rdy4) begin
      off4_q <= off3_q;
      fd4_q  <= fd3_q;
    end
    if (rdyo) begin
      out_q.element_offset <= off4_q;
      out_q.red_value      <= chan_val[0];
      out_q.green_value    <= (ch_eff >= 2'd2) ? chan_val[1] : '0;
      out_q.blue_value     <= (ch_eff == 2'd3) ? chan_val[2] : '0;
      out_q.frame_done     <= fd4_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    rdq_channel u_channel (
      .clk_i           (clk_i),
      .en_i            (ch_en),
      .mag_i           (mag1_q[k]),
      .neg_i           (neg1_q[k]),
      .quantized_i     (quantized_q),
      .inverse_scale_i (inverse_scale_q),
      .zero_point_i    (zero_point_q),
      .value_o         (chan_val[k])
    );
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// ----- design/rdq_sampler.sv -----
// rdq_sampler: source position tracking and nearest-neighbor sample selection.
// Depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_sampler (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      frame_start_i,
  input  wire logic [rdq_pkg::OW_W-1:0]  out_width_i,
  input  wire logic [rdq_pkg::OH_W-1:0]  out_height_i,
  output logic                           keep_o,
  output logic [rdq_pkg::OFF_W-1:0]      base_o,
  output logic                           frame_done_o
);

  logic [rdq_pkg::COL_W-1:0]  col_q, col_d, col;
  logic [rdq_pkg::ROW_W-1:0]  row_q, row_d, row;
  logic [rdq_pkg::OW_W-1:0]   nc_q, nc_d, nc, nc_nxt;
  logic [rdq_pkg::OH_W-1:0]   nr_q, nr_d, nr;
  logic [rdq_pkg::CACC_W-1:0] cacc_q, cacc_d, cacc, cacc_nxt;
  logic [rdq_pkg::RACC_W-1:0] racc_q, racc_d, racc;
  logic                       ris_q, ris_d, ris;
  logic [rdq_pkg::CCMP_W-1:0] col_lim;
  logic [rdq_pkg::RCMP_W-1:0] row_lim;

  always_comb begin
    col  = frame_start_i ? '0 : col_q;
    row  = frame_start_i ? '0 : row_q;
    nc   = frame_start_i ? '0 : nc_q;
    nr   = frame_start_i ? '0 : nr_q;
    cacc = frame_start_i ? '0 : cacc_q;
    racc = frame_start_i ? '0 : racc_q;

    col_lim = rdq_pkg::CCMP_W'({1'b0, col} + 1'b1) * rdq_pkg::CCMP_W'(out_width_i);
    row_lim = rdq_pkg::RCMP_W'({1'b0, row} + 1'b1) * rdq_pkg::RCMP_W'(out_height_i);

    if (col == '0) begin
      ris = (nr < out_height_i) && (rdq_pkg::RCMP_W'(racc) < row_lim);
    end else begin
      ris = ris_q;
    end

    keep_o = ris && (nc < out_width_i) && (rdq_pkg::CCMP_W'(cacc) < col_lim);

    nc_nxt   = keep_o ? nc + 1'b1 : nc;
    cacc_nxt = keep_o ? cacc + rdq_pkg::CACC_W'(rdq_pkg::SRC_WIDTH) : cacc;

    col_d  = col + 1'b1;
    row_d  = row;
    nc_d   = nc_nxt;
    nr_d   = nr;
    cacc_d = cacc_nxt;
    racc_d = racc;
    ris_d  = ris;
    if (col == rdq_pkg::COL_W'(rdq_pkg::SRC_WIDTH - 1)) begin
      col_d  = '0;
      nc_d   = '0;
      cacc_d = '0;
      if (ris) begin
        nr_d   = nr + 1'b1;
        racc_d = racc + rdq_pkg::RACC_W'(rdq_pkg::SRC_HEIGHT);
      end
      if (row == rdq_pkg::ROW_W'(rdq_pkg::SRC_HEIGHT - 1)) begin
        row_d  = '0;
        nr_d   = '0;
        racc_d = '0;
      end else begin
        row_d = row + 1'b1;
      end
    end

    base_o = rdq_pkg::OFF_W'(rdq_pkg::OFF_W'(nr) * rdq_pkg::OFF_W'(out_width_i))
             + rdq_pkg::OFF_W'(nc);
    frame_done_o = (nc == out_width_i - 1'b1) && (nr == out_height_i - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      nc_q   <= '0;
      nr_q   <= '0;
      cacc_q <= '0;
      racc_q <= '0;
      ris_q  <= 1'b0;
    end else if (adv_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      nc_q   <= nc_d;
      nr_q   <= nr_d;
      cacc_q <= cacc_d;
      racc_q <= racc_d;
      ris_q  <= ris_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/rdq_channel.sv -----
// rdq_channel: per-channel value pipeline, int8 quantization or Q1.14 output.
// Three register stages; depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_channel (
  input  wire logic               clk_i,
  input  wire rdq_pkg::pipe_en_t  en_i,
  input  wire logic [7:0]         mag_i,
  input  wire logic               neg_i,
  input  wire logic               quantized_i,
  input  wire logic [31:0]        inverse_scale_i,
  input  wire logic signed [7:0]  zero_point_i,
  output logic signed [15:0]      value_o
);

  logic [rdq_pkg::PROD_W-1:0] prod_q;
  logic [14:0]                q14_2_q, q14_3_q, q14_4_q;
  logic                       neg2_q, neg3_q, neg4_q;
  logic [15:0]                h16_q;
  logic                       sat_q;
  logic [8:0]                 t_q;

  logic [rdq_pkg::PROD_W-1:0] biased;
  logic [23:0]                h;
  logic [32:0]                recip_prod;
  logic signed [10:0]         t_s, zp_s, q_s;
  logic signed [7:0]          q8;
  logic signed [15:0]         q14_s;

  always_comb begin
    biased     = prod_q + rdq_pkg::ROUND_BIAS;
    h          = biased[rdq_pkg::PROD_W-1:16];
    recip_prod = 33'(h16_q) * 33'(rdq_pkg::RECIP_255);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q  <= rdq_pkg::PROD_W'(mag_i) * rdq_pkg::PROD_W'(inverse_scale_i);
      q14_2_q <= rdq_pkg::Q14_LUT[mag_i];
      neg2_q  <= neg_i;
    end
    if (en_i.s3) begin
      h16_q   <= h[15:0];
      sat_q   <= h >= rdq_pkg::SAT_LIMIT;
      q14_3_q <= q14_2_q;
      neg3_q  <= neg2_q;
    end
    if (en_i.s4) begin
      t_q     <= sat_q ? 9'd256 : recip_prod[32:24];
      q14_4_q <= q14_3_q;
      neg4_q  <= neg3_q;
    end
  end

  always_comb begin
    t_s  = neg4_q ? -$signed({2'b00, t_q}) : $signed({2'b00, t_q});
    zp_s = 11'(zero_point_i);
    q_s  = t_s + zp_s;
    if (q_s < -11'sd128) begin
      q8 = -8'sd128;
    end else if (q_s > 11'sd127) begin
      q8 = 8'sd127;
    end else begin
      q8 = q_s[7:0];
    end
    q14_s   = neg4_q ? -$signed({1'b0, q14_4_q}) : $signed({1'b0, q14_4_q});
    value_o = quantized_i ? 16'(q8) : q14_s;
  end

endmodule

`default_nettype wire

// ----- test/rgb565_downscale_quantizer_tb.sv -----
// rgb565_downscale_quantizer_tb: self-checking testbench for the RGB565 downscale quantizer.
// Drives pixel words and register writes, predicts each kept element and compares results.
// Depends on rdq_pkg and rgb565_downscale_quantizer.
`timescale 1ns / 1ps

module rgb565_downscale_quantizer_tb;
  import rdq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  rgb565_downscale_quantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the registers
  logic        sgn_range   = 1'b0;
  logic        quant_en    = 1'b1;
  logic [31:0] recip_scale = 32'd16711680;
  logic [7:0]  zero_pt     = 8'd0;
  logic [8:0]  out_w       = 9'd128;
  logic [7:0]  out_h       = 8'd128;
  logic [1:0]  n_chan      = 2'd3;

  // predictor copy of the position state
  logic [8:0]  src_col  = '0;
  logic [7:0]  src_row  = '0;
  logic [8:0]  out_col  = '0;
  logic [7:0]  out_row  = '0;
  logic [17:0] col_acc  = '0;
  logic [17:0] row_acc  = '0;
  logic        row_hit  = 1'b0;

  out_word_t pending_elems[$];
  out_word_t want;
  int        bad_words = 0;
  int        burst_left = 0;
  int        stall_run = 0;
  int        stall_mode = 0;

  function automatic void apply_reg(cfg_index_e idx, logic [31:0] data);
    case (idx)
      CFG_SIGNED_RANGE:  sgn_range   = data[0];
      CFG_QUANTIZED:     quant_en    = data[0];
      CFG_INVERSE_SCALE: recip_scale = data;
      CFG_ZERO_POINT:    zero_pt     = data[7:0];
      CFG_OUT_WIDTH:     out_w       = data[8:0];
      CFG_OUT_HEIGHT:    out_h       = data[7:0];
      CFG_CHANNELS:      n_chan      = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] scale_channel(logic [7:0] v8);
    longint num, mag, den, q;
    num = longint'(v8);
    if (sgn_range) num = 2 * num - 255;
    mag = (num < 0) ? -num : num;
    if (quant_en) begin
      den = 255 * 65536;
      q = (2 * mag * longint'(recip_scale) + den) / (2 * den);
      if (num < 0) q = -q;
      q = q + longint'($signed(zero_pt));
      if (q < -128) q = -128;
      else if (q > 127) q = 127;
    end else begin
      q = (2 * mag * 16384 + 255) / 510;
      if (num < 0) q = -q;
    end
    return q[15:0];
  endfunction

  function automatic void track_pixel(logic [15:0] px, logic fs);
    int eow, eoh, nch, off;
    out_word_t w;
    eow = (out_w == 0) ? 1 : ((int'(out_w) > SRC_WIDTH) ? SRC_WIDTH : int'(out_w));
    eoh = (out_h == 0) ? 1 : ((int'(out_h) > SRC_HEIGHT) ? SRC_HEIGHT : int'(out_h));
    nch = (n_chan == 0) ? 1 : int'(n_chan);
    if (fs) begin
      src_col = '0; src_row = '0; out_col = '0; out_row = '0;
      col_acc = '0; row_acc = '0;
    end
    if (src_col == 0)
      row_hit = (int'(out_row) < eoh) && (int'(row_acc) < (int'(src_row) + 1) * eoh);
    if (row_hit && int'(out_col) < eow && int'(col_acc) < (int'(src_col) + 1) * eow) begin
      off = (int'(out_row) * eow + int'(out_col)) * nch;
      w.element_offset = off[17:0];
      w.red_value   = scale_channel(8'(int'(px[15:11]) * 255 / 31));
      w.green_value = (nch >= 2) ? scale_channel(8'(int'(px[10:5]) * 255 / 63)) : 16'd0;
      w.blue_value  = (nch >= 3) ? scale_channel(8'(int'(px[4:0]) * 255 / 31)) : 16'd0;
      w.frame_done  = (int'(out_col) == eow - 1) && (int'(out_row) == eoh - 1);
      pending_elems.push_back(w);
      out_col = out_col + 1;
      col_acc = col_acc + SRC_WIDTH;
    end
    src_col = src_col + 1;
    if (src_col >= SRC_WIDTH) begin
      src_col = '0;
      out_col = '0;
      col_acc = '0;
      if (row_hit) begin
        out_row = out_row + 1;
        row_acc = row_acc + SRC_HEIGHT;
      end
      src_row = src_row + 1;
      if (src_row >= SRC_HEIGHT) begin
        src_row = '0;
        out_row = '0;
        row_acc = '0;
      end
    end
  endfunction

  task automatic send_pixel(logic [15:0] px, logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= '{pixel: px, frame_start: fs};
    do @(posedge clk_i); while (in_stall_o);
    track_pixel(px, fs);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(logic [8:0] ow, logic [7:0] oh, logic [1:0] ch);
    write_reg(CFG_OUT_WIDTH, 32'(ow));
    write_reg(CFG_OUT_HEIGHT, 32'(oh));
    write_reg(CFG_CHANNELS, 32'(ch));
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07FF, 1'b0);
    drain_pipe();
  endtask

  task automatic test_value_formats();
    logic        sr_tab  [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic        q_tab   [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    logic [31:0] inv_tab [6] = '{32'd16711680, 32'd16711680, 32'd0, 32'hFFFF_FFFF,
                                 32'd1, 32'h007F_0000};
    logic [7:0]  zp_tab  [6] = '{8'h00, 8'h00, 8'h7F, 8'h80, 8'h05, 8'hFF};
    set_size(9'd320, 8'd240, 2'd3);
    for (int i = 0; i < 6; i++) begin
      write_reg(CFG_SIGNED_RANGE, 32'(sr_tab[i]));
      write_reg(CFG_QUANTIZED, 32'(q_tab[i]));
      write_reg(CFG_INVERSE_SCALE, inv_tab[i]);
      write_reg(CFG_ZERO_POINT, 32'(zp_tab[i]));
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'($urandom), 1'b0);
      drain_pipe();
    end
  endtask

  task automatic test_channels_and_clamp();
    for (int c = 0; c < 3; c++) begin
      write_reg(CFG_CHANNELS, 32'(c));
      send_pixel(16'hA5C3, 1'b1);
      drain_pipe();
    end
    set_size(9'd0, 8'd0, 2'd3);
    send_pixel(16'h5A3C, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    drain_pipe();
    set_size(9'd511, 8'd255, 2'd2);
    send_pixel(16'h8410, 1'b1);
    send_pixel(16'h7BEF, 1'b0);
    drain_pipe();
  endtask

  task automatic test_mid_frame_change();
    write_reg(CFG_QUANTIZED, 32'd0);
    write_reg(CFG_SIGNED_RANGE, 32'd1);
    set_size(9'd160, 8'd240, 2'd3);
    for (int k = 0; k < 200; k++) send_pixel(16'($urandom), k == 0);
    drain_pipe();
    write_reg(CFG_QUANTIZED, 32'd1);
    write_reg(CFG_INVERSE_SCALE, 32'h0080_0000);
    write_reg(CFG_ZERO_POINT, 32'h0000_00F0);
    set_size(9'd300, 8'd100, 2'd1);
    for (int k = 0; k < 200; k++) send_pixel(16'($urandom), 1'b0);
    drain_pipe();
  endtask

  // one source row, then the step into the next row without frame_start
  task automatic test_row_wrap();
    write_reg(CFG_QUANTIZED, 32'd0);
    write_reg(CFG_SIGNED_RANGE, 32'd0);
    set_size(9'd5, 8'd240, 2'd2);
    for (int k = 0; k < SRC_WIDTH + 10; k++)
      send_pixel(16'($urandom), k == 0);
    drain_pipe();
  endtask

  task automatic randomize_regs();
    logic [31:0] inv;
    logic [8:0]  ow;
    logic [7:0]  oh;
    case ($urandom_range(0, 4))
      0: inv = 32'd0;
      1: inv = 32'd1;
      2: inv = 32'hFFFF_FFFF;
      3: inv = $urandom;
      default: inv = $urandom_range(32'h0000_4000, 32'h0200_0000);
    endcase
    case ($urandom_range(0, 5))
      0: ow = 9'd1;
      1: ow = 9'd320;
      2: ow = 9'd0;
      3: ow = 9'($urandom_range(321, 511));
      default: ow = 9'($urandom_range(1, 320));
    endcase
    case ($urandom_range(0, 5))
      0, 1: oh = 8'd1;
      2: oh = 8'd240;
      3: oh = 8'd0;
      4: oh = 8'($urandom_range(241, 255));
      default: oh = 8'($urandom_range(1, 240));
    endcase
    write_reg(CFG_SIGNED_RANGE, 32'($urandom_range(0, 1)));
    write_reg(CFG_QUANTIZED, 32'($urandom_range(0, 1)));
    write_reg(CFG_INVERSE_SCALE, inv);
    write_reg(CFG_ZERO_POINT, 32'($urandom_range(0, 255)));
    set_size(ow, oh, 2'($urandom_range(0, 3)));
  endtask

  task automatic test_random_frames();
    int sent, len;
    sent = 0;
    while (sent < 500) begin
      drain_pipe();
      randomize_regs();
      len = $urandom_range(1, 200);
      for (int k = 0; k < len; k++)
        send_pixel(16'($urandom),
                   (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 63) == 0));
      sent += len;
    end
    drain_pipe();
  endtask

  // receiver back-pressure: free, random, mostly stalled, light
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(8, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= (stall_run[1:0] != 2'd0);
      default: out_stall_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_elems.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: off=%0d r=%0d g=%0d b=%0d done=%0b",
                   out_word_o.element_offset, out_word_o.red_value,
                   out_word_o.green_value, out_word_o.blue_value,
                   out_word_o.frame_done);
        bad_words++;
      end else begin
        want = pending_elems.pop_front();
        if (out_word_o.element_offset !== want.element_offset ||
            out_word_o.red_value !== want.red_value ||
            out_word_o.green_value !== want.green_value ||
            out_word_o.blue_value !== want.blue_value ||
            out_word_o.frame_done !== want.frame_done) begin
          if (bad_words < 10)
            $display({"mismatch: exp off=%0d r=%0d g=%0d b=%0d done=%0b,",
                      " got off=%0d r=%0d g=%0d b=%0d done=%0b"},
                     want.element_offset, want.red_value, want.green_value,
                     want.blue_value, want.frame_done,
                     out_word_o.element_offset, out_word_o.red_value,
                     out_word_o.green_value, out_word_o.blue_value,
                     out_word_o.frame_done);
          bad_words++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_value_formats();
    test_channels_and_clamp();
    test_mid_frame_change();
    test_row_wrap();
    test_random_frames();
    drain_pipe();
    if (bad_words == 0)
      $display("rgb565_downscale_quantizer_tb: done, clean");
    else
      $display("rgb565_downscale_quantizer_tb: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rgb565_downscale_quantizer_tb: done, errors");
    $finish;
  end

endmodule
